### design/llcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package llcr_pkg;
  localparam int LineLenDef = 128;
  localparam int LinesDef = 64;
  localparam logic [1:0] LVL_PLAIN = 2'd0;
  localparam logic [1:0] LVL_WARN = 2'd1;
  localparam logic [1:0] LVL_ERR = 2'd2;
  localparam logic KIND_FEED = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_LBR = 8'h5b;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_PAREN = 8'h28;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [9:0] SGR_ERR = 10'd31;
  localparam logic [9:0] SGR_WARN = 10'd33;
  localparam logic [9:0] ESC_MAX = 10'd999;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [5:0] line_index;
    logic [6:0] char_index;
  } req_t;

  typedef struct packed {
    logic        line_done;
    logic [31:0] lines_total;
    logic [6:0]  lines_kept;
    logic        read_valid;
    logic [1:0]  read_level;
    logic [7:0]  read_length;
    logic [7:0]  read_char;
  } rsp_t;
endpackage
`default_nettype wire

### design/llcr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface llcr_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/llcr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module llcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/llcr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module llcr_front
  import llcr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  llcr_if.sink      in_ch,
  llcr_if.source    q_ch
);
  logic [1:0]  qcnt;
  req_t        q0, q1;
  logic        push, pop;
  assign in_ch.ready = (qcnt != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_ch.valid && q_ch.ready;
  assign q_ch.valid = (qcnt != 2'd0);
  assign q_ch.payload = q0;
  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= 2'd0;
    end else begin
      qcnt <= qcnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      q0 <= (qcnt == 2'd2) ? q1 : in_ch.payload;
      if (push) q1 <= in_ch.payload;
    end else if (push) begin
      if (qcnt == 2'd0) q0 <= in_ch.payload;
      else q1 <= in_ch.payload;
    end
  end
`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst) qcnt != 2'd3)
    else $error("queue count");
  a_full: assert property (@(posedge clk) disable iff (rst) qcnt == 2'd2 |-> !in_ch.ready)
    else $error("full ready");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (qcnt == 2'd1 && pop && !push) |=> qcnt == 2'd0) else $error("pop");
`endif
endmodule
`default_nettype wire

### design/llcr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module llcr_back
  import llcr_pkg::*;
#(
  parameter int LineLen = LineLenDef,
  parameter int Lines = LinesDef
) (
  input  wire logic clk,
  input  wire logic rst,
  llcr_if.sink      q_ch,
  llcr_if.source    out_ch
);
  localparam int PW = $clog2(LineLen);
  localparam int SW = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int TW = SW + PW;
  localparam int TD = 1 << TW;

  typedef enum logic [2:0] {S_IDLE, S_COPY, S_RD, S_OUT} st_t;
  st_t st;

  req_t  r;
  rsp_t  o;
  logic [31:0] cnt;
  logic [7:0]  plen;
  logic [1:0]  plvl;
  logic        ovf;
  logic        ovf_c;
  logic [1:0]  esc;
  logic [9:0]  ev;
  logic [7:0]  c0, c1, c2;
  logic [7:0]  ci;
  logic        cpre;
  logic [SW-1:0] cslot;
  logic [SW-1:0] wslot;
  logic        owait;

  // partial line RAM
  logic          pwe;
  logic [PW-1:0] pwa, pra;
  logic [7:0]    pwd, prd;
  // ring RAMs
  logic          twe, mwe;
  logic [TW-1:0] twa, tra;
  logic [7:0]    trd, pdata;
  logic [SW-1:0] mwa, mra;
  logic [9:0]    mwd, mrd;

  llcr_ram #(.Width(8), .Depth(LineLen)) u_part (
    .clk, .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));
  llcr_ram #(.Width(8), .Depth(TD)) u_text (
    .clk, .we(twe), .waddr(twa), .wdata(pdata), .raddr(tra), .rdata(trd));
  llcr_ram #(.Width(10), .Depth(1 << SW)) u_meta (
    .clk, .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd));

  logic [31:0] kept32;
  logic [6:0]  kept7;
  assign kept32 = (cnt < 32'(Lines)) ? cnt : 32'(Lines);
  assign kept7 = kept32[6:0];

  // byte classification
  logic [7:0] b;
  logic       app;
  logic [7:0] ab;
  logic [13:0] evx;
  assign b = q_ch.payload.data_byte;
  assign evx = {1'b0, ev, 3'b0} + {3'b0, ev, 1'b0} + {10'd0, b[3:0] - 4'd0};
  always_comb begin
    app = 1'b0;
    ab = b;
    if (b == CH_TAB) begin
      app = 1'b1; ab = CH_SPACE;
    end else if (b >= 8'hC0) begin
      app = 1'b1; ab = CH_DASH;
    end else if (b >= CH_SPACE && b != CH_DEL && b < 8'h80) begin
      app = 1'b1;
    end
  end

  logic [SW-1:0] rbase;
  logic [SW:0]   rsum;
  logic [SW-1:0] rslot;
  assign rbase = (cnt < 32'(Lines)) ? '0 : wslot;
  assign rsum = {1'b0, rbase} + (SW+1)'(q_ch.payload.line_index);
  assign rslot = (rsum >= (SW+1)'(Lines)) ? SW'(rsum - (SW+1)'(Lines)) : rsum[SW-1:0];

  logic [1:0] flvl;
  always_comb begin
    flvl = plvl;
    if (plen >= 8'd3 && c1 == CH_SPACE && c2 == CH_PAREN && !(ovf && LineLen < 6)) begin
      if (c0 == CH_E) flvl = LVL_ERR;
      else if (c0 == CH_W && plvl == LVL_PLAIN) flvl = LVL_WARN;
    end
  end

  logic nl_cmt;
  rsp_t fo;
  assign nl_cmt = (esc == 2'd0) && (b == CH_NL);
  always_comb begin
    fo = '0;
    fo.lines_total = cnt;
    fo.lines_kept = kept7;
    if (nl_cmt) begin
      fo.line_done = 1'b1;
      fo.lines_total = cnt + 32'd1;
      fo.lines_kept = (cnt + 32'd1 < 32'(Lines)) ? 7'(cnt + 32'd1) : 7'(Lines);
    end
  end

  logic take;
  assign take = q_ch.valid && q_ch.ready;
  assign q_ch.ready = (st == S_IDLE) && !owait;
  assign out_ch.valid = owait;
  assign out_ch.payload = o;

  always_comb begin
    pdata = prd;
    if (ovf_c && ci >= 8'(LineLen - 2)) pdata = CH_DOT;
  end

  always_comb begin
    pwe = take && q_ch.payload.kind == KIND_FEED && esc == 2'd0 && app
          && plen < 8'(LineLen);
    pwa = PW'(plen);
    pwd = ab;
    pra = PW'(ci);
    twe = (st == S_COPY) && cpre;
    twa = {cslot, PW'(ci - 8'd1)};
    tra = {rslot, PW'(q_ch.payload.char_index)};
    mwe = take && q_ch.payload.kind == KIND_FEED && nl_cmt;
    mwa = wslot;
    mwd = {flvl, plen};
    mra = rslot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cnt <= '0; plen <= '0; plvl <= LVL_PLAIN; ovf <= 1'b0;
      esc <= 2'd0; ev <= '0; owait <= 1'b0; wslot <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) owait <= 1'b0;
      unique case (st)
        S_IDLE: if (take) begin
          r <= q_ch.payload;
          if (q_ch.payload.kind == KIND_READ) begin
            o <= '0;
            st <= S_RD;
          end else begin
            o <= fo;
            st <= nl_cmt ? S_COPY : S_OUT;
            if (esc == 2'd1) begin
              esc <= (b == CH_LBR) ? 2'd2 : 2'd0;
              ev <= '0;
            end else if (esc == 2'd2) begin
              if (b >= 8'h30 && b <= 8'h39) begin
                ev <= (evx > 14'(ESC_MAX)) ? ESC_MAX : evx[9:0];
              end else begin
                if (ev == SGR_ERR) plvl <= LVL_ERR;
                else if (ev == SGR_WARN && plvl == LVL_PLAIN) plvl <= LVL_WARN;
                ev <= '0;
                if (b != CH_SEMI) esc <= 2'd0;
              end
            end else if (b == CH_ESC) begin
              esc <= 2'd1;
            end else if (b == CH_NL) begin
              cnt <= cnt + 32'd1;
              cslot <= wslot;
              wslot <= (cnt == 32'hFFFF_FFFF || wslot == SW'(Lines - 1)) ? '0
                                                                         : wslot + SW'(1);
              ci <= '0; cpre <= 1'b0;
              plen <= '0; plvl <= LVL_PLAIN; ovf <= 1'b0;
            end else if (app) begin
              if (plen < 8'(LineLen)) begin
                plen <= plen + 8'd1;
                if (plen == 8'd0) c0 <= ab;
                if (plen == 8'd1) c1 <= ab;
                if (plen == 8'd2) c2 <= ab;
              end else begin
                ovf <= 1'b1;
              end
            end
          end
        end
        S_COPY: begin
          cpre <= 1'b1;
          ci <= ci + 8'd1;
          if (ci == 8'(LineLen)) begin
            owait <= 1'b1;
            st <= S_IDLE;
          end
        end
        S_RD: begin
          o.lines_total <= cnt;
          o.lines_kept <= kept7;
          if (32'(r.line_index) < kept32) begin
            o.read_valid <= 1'b1;
            o.read_level <= mrd[9:8];
            o.read_length <= mrd[7:0];
            if (8'(r.char_index) < mrd[7:0] && 32'(r.char_index) < 32'(LineLen))
              o.read_char <= trd;
          end
          owait <= 1'b1;
          st <= S_IDLE;
        end
        S_OUT: begin
          owait <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // copy writes delayed data with the overflow marker applied at the old ovf
  always_ff @(posedge clk) if (take && b == CH_NL && esc == 2'd0) ovf_c <= ovf;
`ifndef SYNTHESIS
  a_own: assert property (@(posedge clk) disable iff (rst) owait |-> st == S_IDLE)
    else $error("out hold");
  a_rdy: assert property (@(posedge clk) disable iff (rst) q_ch.ready |-> !owait)
    else $error("ready");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (owait && o.line_done) |-> !o.read_valid) else $error("done");
`endif
endmodule
`default_nettype wire

### design/log_line_capture_ring.sv
// Console line capture ring.
// Channel in_ch carries requests: kind 0 feeds one text byte, kind 1 reads
// one character of a kept line (line_index 0 is the oldest).
// Channel out_ch returns one result per request, in order.
// A two-entry queue parts the input side from the processing core, so a
// request can be taken while the core is busy.
// A newline copies the assembled line into the ring, one byte a cycle
// through the partial-line RAM port.
// The core takes a new request only once the last result has been taken.
// Reset clears counts, level and escape state; ring contents stay undefined
// and are never read before being written.
// When out_ch stalls the result holds and the core stops; the queue then
// fills and in_ch ready falls.
`timescale 1ns / 1ps
`default_nettype none
module log_line_capture_ring
  import llcr_pkg::*;
#(
  parameter int LineLen = LineLenDef,
  parameter int Lines = LinesDef
) (
  input wire logic clk,
  input wire logic rst,
  llcr_if.sink     in_ch,
  llcr_if.source   out_ch
);
  llcr_if #(.payload_t(req_t)) q_ch ();
  llcr_front u_front (.clk, .rst, .in_ch, .q_ch(q_ch));
  llcr_back #(.LineLen(LineLen), .Lines(Lines)) u_back (
    .clk, .rst, .q_ch(q_ch), .out_ch);
endmodule
`default_nettype wire

### tb/log_line_capture_ring_tb.sv
`timescale 1ns / 1ps
module log_line_capture_ring_tb;
  import llcr_pkg::*;

  localparam int LL = LineLenDef;
  localparam int NL = LinesDef;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  llcr_if #(.payload_t(req_t)) req_ch ();
  llcr_if #(.payload_t(rsp_t)) rsp_ch ();

  log_line_capture_ring dut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch.sink),
    .out_ch(rsp_ch.source)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow of the block
  logic [7:0]  ring_text [NL][LL];
  logic [1:0]  ring_level [NL];
  logic [7:0]  ring_len [NL];
  logic [31:0] commits;
  logic [7:0]  cur_text [LL];
  int          cur_len;
  logic [1:0]  cur_level;
  logic        cur_over;
  logic [1:0]  esc_st;
  int          esc_val;

  rsp_t expected_rsps[$];
  bit   failed = 1'b0;
  bit   no_idle = 1'b0;
  bit   hold_off = 1'b0;
  int   quiet_cycles = 0;
  int   sent = 0;

  function automatic logic [6:0] kept_count();
    return (commits < NL) ? commits[6:0] : 7'(NL);
  endfunction

  function automatic void raise_lvl(logic [1:0] lv);
    if (lv > cur_level) cur_level = lv;
  endfunction

  function automatic void push_char(logic [7:0] b);
    if (cur_len < LL) begin
      cur_text[cur_len] = b;
      cur_len++;
    end else begin
      cur_over = 1'b1;
    end
  endfunction

  function automatic void commit_shadow();
    int slot;
    if (cur_over) begin
      cur_text[LL-3] = CH_DOT;
      cur_text[LL-2] = CH_DOT;
      cur_text[LL-1] = CH_DOT;
    end
    if (cur_len >= 3 && cur_text[1] == CH_SPACE && cur_text[2] == CH_PAREN) begin
      if (cur_text[0] == CH_E) raise_lvl(LVL_ERR);
      else if (cur_text[0] == CH_W) raise_lvl(LVL_WARN);
    end
    slot = commits % NL;
    for (int i = 0; i < LL; i++) ring_text[slot][i] = cur_text[i];
    ring_level[slot] = cur_level;
    ring_len[slot] = 8'(cur_len);
    commits++;
    cur_len = 0;
    cur_level = LVL_PLAIN;
    cur_over = 1'b0;
  endfunction

  function automatic bit feed_byte(logic [7:0] b);
    if (esc_st == 2'd1) begin
      esc_st = (b == CH_LBR) ? 2'd2 : 2'd0;
      esc_val = 0;
      return 1'b0;
    end
    if (esc_st == 2'd2) begin
      if (b >= "0" && b <= "9") begin
        esc_val = esc_val * 10 + (b - "0");
        if (esc_val > ESC_MAX) esc_val = ESC_MAX;
        return 1'b0;
      end
      if (esc_val == SGR_ERR) raise_lvl(LVL_ERR);
      else if (esc_val == SGR_WARN) raise_lvl(LVL_WARN);
      esc_val = 0;
      if (b != CH_SEMI) esc_st = 2'd0;
      return 1'b0;
    end
    if (b == CH_ESC) esc_st = 2'd1;
    else if (b == CH_NL) begin
      commit_shadow();
      return 1'b1;
    end else if (b == CH_TAB) push_char(CH_SPACE);
    else if (b >= 8'h80) begin
      if (b >= 8'hc0) push_char(CH_DASH);
    end else if (b >= CH_SPACE && b != CH_DEL) push_char(b);
    return 1'b0;
  endfunction

  function automatic rsp_t predict_line_op(req_t r);
    rsp_t o;
    int kept;
    int slot;
    o = '0;
    if (r.kind == KIND_FEED) begin
      o.line_done = feed_byte(r.data_byte);
    end else begin
      kept = kept_count();
      if (r.line_index < kept) begin
        slot = (commits - kept + r.line_index) % NL;
        o.read_valid = 1'b1;
        o.read_level = ring_level[slot];
        o.read_length = ring_len[slot];
        if (r.char_index < ring_len[slot]) o.read_char = ring_text[slot][r.char_index];
      end
    end
    o.lines_total = commits;
    o.lines_kept = kept_count();
    return o;
  endfunction

  task automatic send_req(req_t r, bit pinned = 1'b0, rsp_t pin = '0);
    rsp_t p;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = predict_line_op(r);
    expected_rsps.push_back(pinned ? pin : p);
    sent++;
  endtask

  function automatic req_t feed(logic [7:0] b);
    req_t r;
    r = '0;
    r.kind = KIND_FEED;
    r.data_byte = b;
    r.line_index = 6'($urandom);
    r.char_index = 7'($urandom);
    return r;
  endfunction

  function automatic req_t rd(int li, int ci);
    req_t r;
    r = '0;
    r.kind = KIND_READ;
    r.data_byte = 8'($urandom);
    r.line_index = 6'(li);
    r.char_index = 7'(ci);
    return r;
  endfunction

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_req(feed(s[i]));
  endtask

  task automatic random_line();
    int n;
    int pick;
    n = (sent < 400 && $urandom_range(0, 15) == 0) ? $urandom_range(120, 140)
                                                   : $urandom_range(0, 12);
    pick = $urandom_range(0, 5);
    if (pick == 0) send_text("E (");
    else if (pick == 1) send_text("W (");
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_text($sformatf("%c[%0dm", CH_ESC, $urandom_range(0, 1) ? 31 : 33));
        1: send_text($sformatf("%c[%0d;%0dm", CH_ESC, $urandom_range(0, 1200),
                               $urandom_range(0, 40)));
        2: send_req(feed(8'($urandom)));
        3: send_req(feed(CH_TAB));
        4: send_text(string'({8'hc3, 8'ha9}));
        5: send_req(feed(CH_ESC));
        default: send_req(feed(8'($urandom_range(32, 126))));
      endcase
    end
    send_req(feed(CH_NL));
    repeat ($urandom_range(0, 3)) send_req(rd($urandom_range(0, 63), $urandom_range(0, 127)));
  endtask

  typedef struct {
    req_t  r;
    bit    pinned;
    rsp_t  pin;
  } row_t;

  row_t directed_rows[$];

  function automatic rsp_t pinned_rsp(bit done, int total, int rv, int lv, int ln, int ch);
    rsp_t o;
    o = '0;
    o.line_done = done;
    o.lines_total = total;
    o.lines_kept = (total < NL) ? 7'(total) : 7'(NL);
    o.read_valid = 1'(rv);
    o.read_level = 2'(lv);
    o.read_length = 8'(ln);
    o.read_char = 8'(ch);
    return o;
  endfunction

  function automatic void add_row(req_t r, bit pinned = 1'b0, rsp_t pin = '0);
    row_t x;
    x.r = r;
    x.pinned = pinned;
    x.pin = pin;
    directed_rows.push_back(x);
  endfunction

  initial begin
    commits = '0;
    cur_len = 0;
    cur_level = LVL_PLAIN;
    cur_over = 1'b0;
    esc_st = 2'd0;
    esc_val = 0;
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(rd(0, 0), 1'b1, pinned_rsp(0, 0, 0, 0, 0, 0));
    add_row(rd(63, 127), 1'b1, pinned_rsp(0, 0, 0, 0, 0, 0));
    add_row(feed(CH_NL), 1'b1, pinned_rsp(1, 1, 0, 0, 0, 0));
    add_row(rd(0, 0), 1'b1, pinned_rsp(0, 1, 1, 0, 0, 0));
    add_row(feed("E"));
    add_row(feed(CH_SPACE));
    add_row(feed(CH_PAREN));
    add_row(feed(CH_TAB));
    add_row(feed(8'hff));
    add_row(feed(8'h80));
    add_row(feed(8'h00));
    add_row(feed(CH_DEL));
    add_row(feed(8'h0d));
    add_row(feed(CH_NL), 1'b1, pinned_rsp(1, 2, 0, 0, 0, 0));
    add_row(rd(1, 0), 1'b1, pinned_rsp(0, 2, 1, LVL_ERR, 5, CH_E));
    add_row(rd(1, 3), 1'b1, pinned_rsp(0, 2, 1, LVL_ERR, 5, CH_SPACE));
    add_row(rd(1, 4), 1'b1, pinned_rsp(0, 2, 1, LVL_ERR, 5, CH_DASH));
    add_row(rd(1, 5), 1'b1, pinned_rsp(0, 2, 1, LVL_ERR, 5, 0));
    add_row(rd(2, 0), 1'b1, pinned_rsp(0, 2, 0, 0, 0, 0));
    foreach (directed_rows[i])
      send_req(directed_rows[i].r, directed_rows[i].pinned, directed_rows[i].pin);

    send_text(string'({"W (", 8'h1b, "[9999;31m", 8'h1b, "x", 8'h1b, "[33m"}));
    for (int i = 0; i < 135; i++) send_req(feed(8'(8'h41 + i % 26)));
    send_req(feed(CH_NL));
    send_req(rd(2, 127));
    send_req(rd(2, 126));

    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_req(rd(i % 3, i));

    while (sent < 600) begin
      random_line();
      if (sent > 480) no_idle = 1'b1;
    end
    for (int i = 0; i < 20; i++) send_req(rd($urandom_range(0, 63), $urandom_range(0, 127)));
    req_ch.valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (2 * LL + 20) @(posedge clk);
    if (!failed) $display("log_line_capture_ring test passed");
    else $display("log_line_capture_ring test failed");
    $finish;
  end

  // receiver
  initial begin
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (expected_rsps.size() == 0) begin
        $error("unexpected result %p", got);
        failed = 1'b1;
      end else begin
        want = expected_rsps.pop_front();
        if (got.line_done !== want.line_done) begin
          $error("line_done exp %0d got %0d", want.line_done, got.line_done);
          failed = 1'b1;
        end
        if (got.lines_total !== want.lines_total) begin
          $error("lines_total exp %0d got %0d", want.lines_total, got.lines_total);
          failed = 1'b1;
        end
        if (got.lines_kept !== want.lines_kept) begin
          $error("lines_kept exp %0d got %0d", want.lines_kept, got.lines_kept);
          failed = 1'b1;
        end
        if (got.read_valid !== want.read_valid) begin
          $error("read_valid exp %0d got %0d", want.read_valid, got.read_valid);
          failed = 1'b1;
        end
        if (got.read_level !== want.read_level) begin
          $error("read_level exp %0d got %0d", want.read_level, got.read_level);
          failed = 1'b1;
        end
        if (got.read_length !== want.read_length) begin
          $error("read_length exp %0d got %0d", want.read_length, got.read_length);
          failed = 1'b1;
        end
        if (got.read_char !== want.read_char) begin
          $error("read_char exp %0h got %0h", want.read_char, got.read_char);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst
        || hold_off)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("log_line_capture_ring test failed");
      $finish;
    end
  end
endmodule

### files.f
design/llcr_pkg.sv
design/llcr_if.sv
design/llcr_ram.sv
design/llcr_front.sv
design/llcr_back.sv
design/log_line_capture_ring.sv
tb/log_line_capture_ring_tb.sv
